/* rtl/tcsb_pkg.sv */
// Shared constants and types of the text console scroll buffer.
`default_nettype none
package tcsb_pkg;
   localparam int MAX_COLUMNS = 128;
   localparam int MAX_ROWS    = 64;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int ADDR_W      = ROW_W + COL_W;
   localparam int CELLS       = MAX_ROWS * MAX_COLUMNS;
   localparam int CELL_W      = 9;

   localparam logic [7:0] NEWLINE_BYTE    = 8'd10;
   localparam logic [3:0] FG_BRIGHT_WHITE = 4'd15;
   localparam logic [3:0] BG_BLACK        = 4'd0;
   localparam logic [7:0] COLUMNS_RESET   = 8'd80;
   localparam logic [6:0] ROWS_RESET      = 7'd25;

   localparam logic       CSR_COLUMNS = 1'b0;
   localparam logic       CSR_ROWS    = 1'b1;
   localparam logic       FUNC_WRITE  = 1'b0;
   localparam logic       FUNC_READ   = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PREP,
      ST_SCROLL,
      ST_STORE,
      ST_RD_ADDR,
      ST_RD_DATA
   } state_type;
endpackage
`default_nettype wire

/* rtl/tcsb_ram.sv */
// Generic single-port RAM with registered read data.
`default_nettype none
module tcsb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output      logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

/* rtl/text_console_scroll_buffer_top.sv */
// Top level of the text console scroll buffer: cursor sequencer around one cell RAM.
// A write request keeps the input busy through ST_PREP and ST_STORE after acceptance, and
// ST_SCROLL, which clears MAX_COLUMNS (128) cells, when it scrolls first; a read response
// goes valid after ST_RD_ADDR and ST_RD_DATA, which waits for a free response slot. One
// request is in work at a time. Reset is synchronous, active high; afterwards a clearing pass
// over all 8192 cells zeroes the cell RAM, during which no request is taken (CSR writes are).
`default_nettype none
module text_console_scroll_buffer_top
   import tcsb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [23:0] req_tdata,   // char_byte[7:0], read_column[14:8], read_row[20:15]
   input  wire logic        req_tlast,   // end_of_write
   input  wire logic        req_tuser,   // func
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata,   // char_code[7:0], foreground[11:8], background[15:12]
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_data
);
   state_type         state_ff, state_in;
   logic [7:0]        columns_ff;
   logic [6:0]        rows_ff;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W:0]    row_ff, row_in;
   logic [ROW_W-1:0]  top_ff, top_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic              func_ff;
   logic [7:0]        byte_ff;
   logic [COL_W-1:0]  rcol_ff;
   logic [ROW_W-1:0]  rrow_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_data_ff, rsp_data_in;

   logic [COL_W:0]    nc;
   logic [ROW_W:0]    nr;
   logic [ROW_W-1:0]  nr_m1;
   logic [ROW_W-1:0]  row_op;
   logic [ROW_W-1:0]  phys;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [CELL_W-1:0] ram_wdata;
   logic [CELL_W-1:0] ram_rdata;
   logic              req_fire;
   logic              slot_free;
   logic              wrap;
   logic [COL_W-1:0]  col1;
   logic [ROW_W:0]    row1;
   logic [COL_W:0]    col_inc;
   logic              in_range;

   assign nc = (columns_ff == 8'd0) ? (COL_W+1)'(1) :
               (columns_ff > 8'(MAX_COLUMNS)) ? (COL_W+1)'(MAX_COLUMNS) :
               (COL_W+1)'(columns_ff);
   assign nr = (rows_ff == 7'd0) ? (ROW_W+1)'(1) :
               (rows_ff > 7'(MAX_ROWS)) ? (ROW_W+1)'(MAX_ROWS) :
               (ROW_W+1)'(rows_ff);
   assign nr_m1 = ROW_W'(nr - (ROW_W+1)'(1));

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      case (state_ff)
         ST_SCROLL: row_op = nr_m1;
         ST_STORE:  row_op = row_ff[ROW_W-1:0];
         default:   row_op = rrow_ff;
      endcase
   end
   assign phys = top_ff + row_op;

   assign wrap    = {1'b0, col_ff} >= nc;
   assign col1    = wrap ? '0 : col_ff;
   assign row1    = wrap ? row_ff + (ROW_W+1)'(1) : row_ff;
   assign col_inc = {1'b0, col_ff} + (COL_W+1)'(1);
   assign in_range = ({1'b0, rcol_ff} < nc) && ({1'b0, rrow_ff} < nr);

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      top_in       = top_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_addr     = {phys, rcol_ff};
      ram_wdata    = '0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we   = 1'b1;
            ram_addr = clr_ff;
            clr_in   = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_tuser == FUNC_READ) ? ST_RD_ADDR : ST_PREP;
            end
         end
         ST_PREP: begin
            if (row1 >= nr) begin
               top_in   = top_ff + ROW_W'(1);
               clr_in   = '0;
               col_in   = '0;
               row_in   = {1'b0, nr_m1};
               state_in = ST_SCROLL;
            end else begin
               col_in   = col1;
               row_in   = row1;
               state_in = ST_STORE;
            end
         end
         ST_SCROLL: begin
            ram_we   = 1'b1;
            ram_addr = {phys, clr_ff[COL_W-1:0]};
            clr_in   = clr_ff + ADDR_W'(1);
            if (clr_ff[COL_W-1:0] == COL_W'(MAX_COLUMNS - 1)) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            ram_addr = {phys, col_ff};
            if (byte_ff == NEWLINE_BYTE) begin
               col_in = '0;
               row_in = row_ff + (ROW_W+1)'(1);
            end else begin
               ram_we    = 1'b1;
               ram_wdata = {1'b1, byte_ff};
               if (col_inc >= nc) begin
                  col_in = '0;
                  row_in = row_ff + (ROW_W+1)'(1);
               end else begin
                  col_in = col_inc[COL_W-1:0];
               end
            end
            state_in = ST_IDLE;
         end
         ST_RD_ADDR: begin
            state_in = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (in_range) begin
                  rsp_data_in = {BG_BLACK, ram_rdata[8] ? FG_BRIGHT_WHITE : 4'd0,
                                 ram_rdata[7:0]};
               end else begin
                  rsp_data_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         columns_ff   <= COLUMNS_RESET;
         rows_ff      <= ROWS_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         top_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         top_ff       <= top_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COLUMNS: columns_ff <= csr_data;
               CSR_ROWS:    rows_ff    <= csr_data[6:0];
               default:     ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (req_fire) begin
         func_ff <= req_tuser;
         byte_ff <= req_tdata[7:0];
         rcol_ff <= req_tdata[14:8];
         rrow_ff <= req_tdata[20:15];
      end
   end

   tcsb_ram #(
      .WIDTH(CELL_W),
      .DEPTH(CELLS)
   ) u_cells (
      .clock(clock),
      .we   (ram_we && (func_ff == FUNC_WRITE || state_ff == ST_CLEAR)),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );
endmodule
`default_nettype wire
